/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes for the banker's safety checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int DEF_MAX_PROCESSES = 8;
   localparam int DEF_MAX_RESOURCES = 3;
   localparam int DEF_COUNT_WIDTH   = 8;

   localparam int FIELD_WIDTH = 8;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [1:0] {
      FN_CLEAR   = 2'd0,
      FN_LOAD    = 2'd1,
      FN_REQUEST = 2'd2,
      FN_CHECK   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_PROC   = 3'd1,
      ST_OVER_NEED  = 3'd2,
      ST_OVER_AVAIL = 3'd3,
      ST_UNSAFE     = 3'd4,
      ST_BAD_LOAD   = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL0    = 3'd0,
      CSR_TOTAL1    = 3'd1,
      CSR_TOTAL2    = 3'd2,
      CSR_NUM_PROCS = 3'd3,
      CSR_NUM_RES   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic       latch;
      logic       clear;
      logic       load;
      logic       grant;
      logic       rollback;
      logic       scan_init;
      logic       scan_step;
      logic       seq_shift;
      logic       emit;
      status_type code;
      logic       last;
   } cmd_type;

   typedef struct packed {
      func_type   func;
      logic [2:0] pid;
      logic       bad_proc;
      logic       load_bad;
      status_type req_code;
      logic       row_fits;
      logic       count_full;
      logic       out_free;
   } dp_status_type;

endpackage

/* hdl/bsc_req_if.sv */
// ----------------------------------------------------------------------------
// bsc_req_if
// Request channel: command, process row and amounts.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] proc_index;
   logic [7:0] amount0;
   logic [7:0] amount1;
   logic [7:0] amount2;
   logic [7:0] held0;
   logic [7:0] held1;
   logic [7:0] held2;

   modport source (output valid, func, proc_index, amount0, amount1, amount2,
                   held0, held1, held2, input ready);
   modport sink (input valid, func, proc_index, amount0, amount1, amount2,
                 held0, held1, held2, output ready);
endinterface

/* hdl/bsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Response channel: status, safe sequence entry and available vector.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [2:0] seq_proc;
   logic       last;
   logic [7:0] avail0;
   logic [7:0] avail1;
   logic [7:0] avail2;

   modport source (output valid, status, seq_proc, last, avail0, avail1, avail2,
                   input ready);
   modport sink (input valid, status, seq_proc, last, avail0, avail1, avail2,
                 output ready);
endinterface

/* hdl/bsc_datapath.sv */
// ----------------------------------------------------------------------------
// bsc_datapath
// Allocation/need tables, available and work vectors, safe sequence and
// the response register.
// ----------------------------------------------------------------------------
module bsc_datapath #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 3,
   parameter int COUNT_WIDTH   = 8,
   parameter int IW            = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   parameter int PW            = $clog2(MAX_PROCESSES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsc_pkg::cmd_type      cmd,
   input  logic [IW-1:0]         row_sel,
   output bsc_pkg::dp_status_type st,
   output logic [PW-1:0]         np_eff,
   input  logic [7:0]            total_cfg [3],
   input  logic [3:0]            num_procs_cfg,
   input  logic [1:0]            num_res_cfg,
   input  logic [1:0]            in_func,
   input  logic [2:0]            in_pid,
   input  logic [7:0]            in_amt [3],
   input  logic [7:0]            in_held [3],
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [2:0]            rsp_seq_proc,
   output logic                  rsp_last,
   output logic [7:0]            rsp_avail [3]
);
   import bsc_pkg::*;

   localparam int EW = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   function automatic logic [COUNT_WIDTH-1:0] sat_in(input logic [7:0] v);
      logic [EW-1:0] ve;
      ve = EW'(v);
      return (ve > EW'(CMAX)) ? CMAX : ve[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? CMAX : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [7:0] to_field(input logic [COUNT_WIDTH-1:0] v);
      logic [EW-1:0] ve;
      ve = EW'(v);
      return ve[7:0];
   endfunction

   func_type               func_ff;
   logic [2:0]             pid_ff;
   logic [COUNT_WIDTH-1:0] amt_ff  [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] held_ff [MAX_RESOURCES];

   logic [COUNT_WIDTH-1:0] alloc_ff [MAX_PROCESSES][MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] need_ff  [MAX_PROCESSES][MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] avail_ff [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] work_ff  [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] done_ff;
   logic [IW-1:0]          seq_ff [MAX_PROCESSES];
   logic [PW-1:0]          count_ff;

   logic                   rsp_valid_ff;
   status_type             status_ff;
   logic [2:0]             seqp_ff;
   logic                   last_ff;
   logic [7:0]             av_ff [3];

   logic [1:0]             nr_eff;
   logic [COUNT_WIDTH-1:0] freed [MAX_RESOURCES];
   logic                   load_bad;
   logic                   fits_all;
   status_type             req_code;

   always_comb begin
      if (num_procs_cfg == 4'd0)
         np_eff = PW'(1);
      else if (int'(num_procs_cfg) > MAX_PROCESSES)
         np_eff = PW'(MAX_PROCESSES);
      else
         np_eff = PW'(num_procs_cfg);
      if (num_res_cfg == 2'd0)
         nr_eff = 2'd1;
      else if (int'(num_res_cfg) > MAX_RESOURCES)
         nr_eff = 2'(MAX_RESOURCES);
      else
         nr_eff = num_res_cfg;
   end

   always_comb begin
      load_bad = 1'b0;
      fits_all = ~done_ff[row_sel];
      req_code = ST_OK;
      for (int j = 0; j < MAX_RESOURCES; j++) begin
         freed[j] = sat_add(avail_ff[j], alloc_ff[row_sel][j]);
         if (j < int'(nr_eff)) begin
            if (held_ff[j] > amt_ff[j] || held_ff[j] > freed[j])
               load_bad = 1'b1;
            if (need_ff[row_sel][j] > work_ff[j])
               fits_all = 1'b0;
         end
      end
      for (int j = MAX_RESOURCES - 1; j >= 0; j--) begin
         if (j < int'(nr_eff)) begin
            if (amt_ff[j] > need_ff[row_sel][j])
               req_code = ST_OVER_NEED;
            else if (amt_ff[j] > avail_ff[j])
               req_code = ST_OVER_AVAIL;
         end
      end
   end

   assign st.func       = func_ff;
   assign st.pid        = pid_ff;
   assign st.bad_proc   = (PW + 1)'(pid_ff) >= (PW + 1)'(np_eff);
   assign st.load_bad   = load_bad;
   assign st.req_code   = req_code;
   assign st.row_fits   = fits_all;
   assign st.count_full = count_ff == np_eff;
   assign st.out_free   = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCESSES; i++) begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               alloc_ff[i][j] <= '0;
               need_ff[i][j]  <= '0;
            end
         end
         for (int j = 0; j < MAX_RESOURCES; j++)
            avail_ff[j] <= '0;
         done_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.latch) begin
            func_ff <= func_type'(in_func);
            pid_ff  <= in_pid;
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               amt_ff[j]  <= sat_in(in_amt[j]);
               held_ff[j] <= sat_in(in_held[j]);
            end
         end
         if (cmd.clear) begin
            for (int j = 0; j < MAX_RESOURCES; j++)
               avail_ff[j] <= sat_in(total_cfg[j]);
            for (int i = 0; i < MAX_PROCESSES; i++) begin
               for (int j = 0; j < MAX_RESOURCES; j++) begin
                  alloc_ff[i][j] <= '0;
                  need_ff[i][j]  <= '0;
               end
            end
         end
         if (cmd.load) begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               if (j < int'(nr_eff)) begin
                  avail_ff[j]          <= freed[j] - held_ff[j];
                  alloc_ff[row_sel][j] <= held_ff[j];
                  need_ff[row_sel][j]  <= amt_ff[j] - held_ff[j];
               end else begin
                  avail_ff[j]          <= freed[j];
                  alloc_ff[row_sel][j] <= '0;
                  need_ff[row_sel][j]  <= '0;
               end
            end
         end
         if (cmd.grant) begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               if (j < int'(nr_eff)) begin
                  avail_ff[j]          <= avail_ff[j] - amt_ff[j];
                  alloc_ff[row_sel][j] <= sat_add(alloc_ff[row_sel][j], amt_ff[j]);
                  need_ff[row_sel][j]  <= need_ff[row_sel][j] - amt_ff[j];
               end
            end
         end
         if (cmd.rollback) begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               if (j < int'(nr_eff)) begin
                  avail_ff[j]          <= avail_ff[j] + amt_ff[j];
                  alloc_ff[row_sel][j] <= alloc_ff[row_sel][j] - amt_ff[j];
                  need_ff[row_sel][j]  <= need_ff[row_sel][j] + amt_ff[j];
               end
            end
         end
         if (cmd.scan_init) begin
            for (int j = 0; j < MAX_RESOURCES; j++)
               work_ff[j] <= avail_ff[j];
            done_ff  <= '0;
            count_ff <= '0;
         end
         if (cmd.scan_step && fits_all) begin
            done_ff[row_sel] <= 1'b1;
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               if (j < int'(nr_eff))
                  work_ff[j] <= sat_add(work_ff[j], alloc_ff[row_sel][j]);
            end
            seq_ff[count_ff[IW-1:0]] <= row_sel;
            count_ff <= count_ff + PW'(1);
         end
         if (cmd.seq_shift) begin
            for (int k = 0; k < MAX_PROCESSES - 1; k++)
               seq_ff[k] <= seq_ff[k + 1];
         end
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (cmd.emit) begin
            status_ff    <= cmd.code;
            seqp_ff      <= cmd.seq_shift ? 3'(seq_ff[0]) : 3'd0;
            last_ff      <= cmd.last;
            for (int j = 0; j < 3; j++)
               av_ff[j] <= (j < MAX_RESOURCES) ? to_field(avail_ff[j]) : 8'd0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_seq_proc = seqp_ff;
   assign rsp_last     = last_ff;
   assign rsp_avail    = av_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> count_ff <= np_eff) else $error("scan count beyond rows in use");

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) == int'(count_ff)) else $error("done bits and count disagree");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff) else $error("emitted beat not presented");

endmodule

/* hdl/bsc_ctrl.sv */
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: decode, trial grant, row-by-row safety scan, rollback, emit.
// ----------------------------------------------------------------------------
module bsc_ctrl #(
   parameter int MAX_PROCESSES = 8,
   parameter int IW            = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   parameter int PW            = $clog2(MAX_PROCESSES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bsc_pkg::dp_status_type st,
   input  logic [PW-1:0]          np_eff,
   output bsc_pkg::cmd_type       cmd,
   output logic [IW-1:0]          row_sel
);
   import bsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_START, S_SCAN, S_CHECK, S_ROLLBACK, S_SEQ, S_RESULT
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] row_ff, row_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic [PW-1:0] k_ff, k_in;
   logic          prog_ff, prog_in;
   status_type    code_ff, code_in;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      pass_in   = pass_ff;
      k_in      = k_ff;
      prog_in   = prog_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = ST_OK;
      row_sel   = IW'(st.pid);
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            code_in  = ST_OK;
            if (st.func == FN_CLEAR) begin
               cmd.clear = 1'b1;
            end else if (st.func == FN_CHECK) begin
               state_in = S_START;
            end else if (st.bad_proc) begin
               code_in = ST_BAD_PROC;
            end else if (st.func == FN_LOAD) begin
               if (st.load_bad)
                  code_in = ST_BAD_LOAD;
               else
                  cmd.load = 1'b1;
            end else if (st.req_code != ST_OK) begin
               code_in = st.req_code;
            end else begin
               cmd.grant = 1'b1;
               state_in  = S_START;
            end
         end
         S_START: begin
            cmd.scan_init = 1'b1;
            row_in        = '0;
            pass_in       = '0;
            prog_in       = 1'b0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            row_sel       = row_ff;
            cmd.scan_step = 1'b1;
            if (st.row_fits)
               prog_in = 1'b1;
            if (PW'(row_ff) + PW'(1) == np_eff)
               state_in = S_CHECK;
            else
               row_in = row_ff + IW'(1);
         end
         S_CHECK: begin
            if (st.count_full) begin
               k_in     = '0;
               state_in = S_SEQ;
            end else if (!prog_ff || pass_ff + PW'(1) == np_eff) begin
               code_in  = ST_UNSAFE;
               state_in = (st.func == FN_REQUEST) ? S_ROLLBACK : S_RESULT;
            end else begin
               pass_in  = pass_ff + PW'(1);
               row_in   = '0;
               prog_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_ROLLBACK: begin
            cmd.rollback = 1'b1;
            state_in     = S_RESULT;
         end
         S_SEQ: begin
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.seq_shift = 1'b1;
               cmd.last      = (k_ff + PW'(1) == np_eff);
               k_in          = k_ff + PW'(1);
               if (cmd.last)
                  state_in = S_IDLE;
            end
         end
         S_RESULT: begin
            cmd.code = code_ff;
            if (st.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         pass_ff  <= '0;
         k_ff     <= '0;
         prog_ff  <= 1'b0;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         pass_ff  <= pass_in;
         k_ff     <= k_in;
         prog_ff  <= prog_in;
         code_ff  <= code_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE) else $error("accept outside idle");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_CHECK) |-> pass_ff < np_eff)
      else $error("scan pass overrun");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> PW'(row_ff) < np_eff) else $error("scan row overrun");

endmodule

/* hdl/bankers_safety_checker_top.sv */
// ----------------------------------------------------------------------------
// bankers_safety_checker_top
// Banker's-algorithm resource manager with sequential safety scan.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Clear, load and rejected requests get
// their single response beat after decode. A request that passes its checks,
// or a safety check, runs the scan one process row per cycle, with a check
// state after each pass and at most P passes for P rows in use, followed by
// one response beat per safe-sequence entry (P beats when safe); when unsafe,
// a request is rolled back before the single beat. Configuration must be
// written through csr_we/csr_index/csr_wdata only while the block is idle;
// the block itself does not enforce this.
module bankers_safety_checker_top #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_WIDTH   = bsc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   bsc_req_if.sink                       req,
   bsc_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);
   import bsc_pkg::*;

   localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int PW = $clog2(MAX_PROCESSES + 1);

   logic [7:0]    total_ff [3];
   logic [3:0]    num_procs_ff;
   logic [1:0]    num_res_ff;

   cmd_type       cmd;
   dp_status_type st;
   logic [IW-1:0] row_sel;
   logic [PW-1:0] np_eff;
   logic [7:0]    in_amt [3];
   logic [7:0]    in_held [3];
   logic [7:0]    out_avail [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++)
            total_ff[j] <= '0;
         num_procs_ff <= 4'd8;
         num_res_ff   <= 2'd3;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TOTAL0:    total_ff[0]  <= csr_wdata;
            CSR_TOTAL1:    total_ff[1]  <= csr_wdata;
            CSR_TOTAL2:    total_ff[2]  <= csr_wdata;
            CSR_NUM_PROCS: num_procs_ff <= csr_wdata[3:0];
            CSR_NUM_RES:   num_res_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign in_amt[0]  = req.amount0;
   assign in_amt[1]  = req.amount1;
   assign in_amt[2]  = req.amount2;
   assign in_held[0] = req.held0;
   assign in_held[1] = req.held1;
   assign in_held[2] = req.held2;

   assign rsp.avail0 = out_avail[0];
   assign rsp.avail1 = out_avail[1];
   assign rsp.avail2 = out_avail[2];

   bsc_ctrl #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .IW            (IW),
      .PW            (PW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .st        (st),
      .np_eff    (np_eff),
      .cmd       (cmd),
      .row_sel   (row_sel)
   );

   bsc_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .IW            (IW),
      .PW            (PW)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .row_sel       (row_sel),
      .st            (st),
      .np_eff        (np_eff),
      .total_cfg     (total_ff),
      .num_procs_cfg (num_procs_ff),
      .num_res_cfg   (num_res_ff),
      .in_func       (req.func),
      .in_pid        (req.proc_index),
      .in_amt        (in_amt),
      .in_held       (in_held),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_status    (rsp.status),
      .rsp_seq_proc  (rsp.seq_proc),
      .rsp_last      (rsp.last),
      .rsp_avail     (out_avail)
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the banker's safety checker. A directed table and
// randomized phases of row loads, requests, checks and noise jobs go through
// the request channel. A built-in banker's predictor tracks the allocation,
// need and available state and queues the expected response beats, which are
// compared field by field as they arrive. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import bsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      func_type         func;
      logic [2:0]       pid;
      logic [2:0][7:0]  amt;
      logic [2:0][7:0]  held;
   } job_type;

   typedef struct packed {
      status_type       status;
      logic [2:0]       seq_proc;
      logic             last;
      logic [2:0][7:0]  avail;
   } beat_type;

   typedef struct {
      bit               is_csr;
      csr_index_type    idx;
      logic [7:0]       wdata;
      job_type          job;
      int               want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   bsc_req_if req_if ();
   bsc_rsp_if rsp_if ();

   bankers_safety_checker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0] alloc_tab [8][3];
   logic [7:0] need_tab [8][3];
   logic [7:0] avail_vec [3];
   logic [7:0] cfg_total [3];
   logic [3:0] cfg_np;
   logic [1:0] cfg_nr;

   beat_type expected_beats [$];
   int    errors = 0;
   int    cycles = 0;
   int    burst_left = 0;
   int    stall_mode = 0;

   function automatic int rows_in_use();
      return (cfg_np < 1) ? 1 : ((cfg_np > 8) ? 8 : int'(cfg_np));
   endfunction

   function automatic int res_in_use();
      return (cfg_nr < 1) ? 1 : int'(cfg_nr);
   endfunction

   function automatic int sat8(int v);
      return (v > 255) ? 255 : v;
   endfunction

   function automatic void push_beat(status_type st, logic [2:0] sp, logic lst);
      beat_type b;
      b.status = st;
      b.seq_proc = sp;
      b.last = lst;
      for (int j = 0; j < 3; j++) b.avail[j] = avail_vec[j];
      expected_beats.push_back(b);
   endfunction

   // runs the safety scan; pushes the safe order when safe
   function automatic bit scan_and_emit(int np, int nr);
      int  work [3];
      bit  done [8];
      int  order [8];
      int  cnt;
      int  prior;
      bit  fits;
      cnt = 0;
      for (int j = 0; j < 3; j++) work[j] = avail_vec[j];
      for (int i = 0; i < 8; i++) done[i] = 1'b0;
      for (int pass = 0; pass < np && cnt < np; pass++) begin
         prior = cnt;
         for (int i = 0; i < np; i++) begin
            if (done[i]) continue;
            fits = 1'b1;
            for (int j = 0; j < nr; j++)
               if (need_tab[i][j] > work[j]) fits = 1'b0;
            if (!fits) continue;
            done[i] = 1'b1;
            for (int j = 0; j < nr; j++) work[j] = sat8(work[j] + alloc_tab[i][j]);
            order[cnt] = i;
            cnt++;
         end
         if (cnt == prior) break;
      end
      if (cnt != np) return 1'b0;
      for (int i = 0; i < np; i++) push_beat(ST_OK, 3'(order[i]), (i + 1 == np));
      return 1'b1;
   endfunction

   function automatic void predict_beats(job_type jb);
      int np;
      int nr;
      int p;
      int freed [3];
      status_type code;
      np = rows_in_use();
      nr = res_in_use();
      p = jb.pid;
      case (jb.func)
         FN_CLEAR: begin
            for (int j = 0; j < 3; j++) avail_vec[j] = cfg_total[j];
            for (int i = 0; i < 8; i++)
               for (int j = 0; j < 3; j++) begin
                  alloc_tab[i][j] = '0;
                  need_tab[i][j] = '0;
               end
            push_beat(ST_OK, 3'd0, 1'b1);
         end
         FN_CHECK: begin
            if (!scan_and_emit(np, nr)) push_beat(ST_UNSAFE, 3'd0, 1'b1);
         end
         FN_LOAD: begin
            if (p >= np) begin
               push_beat(ST_BAD_PROC, 3'd0, 1'b1);
               return;
            end
            for (int j = 0; j < 3; j++) freed[j] = sat8(avail_vec[j] + alloc_tab[p][j]);
            for (int j = 0; j < nr; j++)
               if (jb.held[j] > jb.amt[j] || jb.held[j] > freed[j]) begin
                  push_beat(ST_BAD_LOAD, 3'd0, 1'b1);
                  return;
               end
            for (int j = 0; j < 3; j++) begin
               if (j < nr) begin
                  alloc_tab[p][j] = jb.held[j];
                  need_tab[p][j] = jb.amt[j] - jb.held[j];
                  avail_vec[j] = 8'(freed[j] - jb.held[j]);
               end else begin
                  alloc_tab[p][j] = '0;
                  need_tab[p][j] = '0;
                  avail_vec[j] = 8'(freed[j]);
               end
            end
            push_beat(ST_OK, 3'd0, 1'b1);
         end
         default: begin
            if (p >= np) begin
               push_beat(ST_BAD_PROC, 3'd0, 1'b1);
               return;
            end
            code = ST_OK;
            for (int j = 0; j < nr; j++)
               if (code == ST_OK) begin
                  if (jb.amt[j] > need_tab[p][j]) code = ST_OVER_NEED;
                  else if (jb.amt[j] > avail_vec[j]) code = ST_OVER_AVAIL;
               end
            if (code != ST_OK) begin
               push_beat(code, 3'd0, 1'b1);
               return;
            end
            for (int j = 0; j < nr; j++) begin
               avail_vec[j] -= jb.amt[j];
               alloc_tab[p][j] += jb.amt[j];
               need_tab[p][j] -= jb.amt[j];
            end
            if (!scan_and_emit(np, nr)) begin
               for (int j = 0; j < nr; j++) begin
                  avail_vec[j] += jb.amt[j];
                  alloc_tab[p][j] -= jb.amt[j];
                  need_tab[p][j] += jb.amt[j];
               end
               push_beat(ST_UNSAFE, 3'd0, 1'b1);
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // one beat; valid stays high into the next beat only when more follows
   task automatic send_job(job_type jb, bit more);
      req_if.func       <= jb.func;
      req_if.proc_index <= jb.pid;
      req_if.amount0    <= jb.amt[0];
      req_if.amount1    <= jb.amt[1];
      req_if.amount2    <= jb.amt[2];
      req_if.held0      <= jb.held[0];
      req_if.held1      <= jb.held[1];
      req_if.held2      <= jb.held[2];
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_beats(jb);
      if (more && burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         if (more) begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end
      end
   endtask

   task automatic drain();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TOTAL0:    cfg_total[0] = data;
         CSR_TOTAL1:    cfg_total[1] = data;
         CSR_TOTAL2:    cfg_total[2] = data;
         CSR_NUM_PROCS: cfg_np = data[3:0];
         default:       cfg_nr = data[1:0];
      endcase
   endtask

   function automatic plan_row_type op(func_type f, int pid, int a0, int a1, int a2,
                                       int h0, int h1, int h2, int want);
      plan_row_type r;
      r.is_csr = 1'b0;
      r.idx = CSR_TOTAL0;
      r.wdata = '0;
      r.job.func = f;
      r.job.pid = 3'(pid);
      r.job.amt = {8'(a2), 8'(a1), 8'(a0)};
      r.job.held = {8'(h2), 8'(h1), 8'(h0)};
      r.want = want;
      return r;
   endfunction

   function automatic plan_row_type cfg(csr_index_type idx, int data);
      plan_row_type r;
      r = op(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, -1);
      r.is_csr = 1'b1;
      r.idx = idx;
      r.wdata = 8'(data);
      return r;
   endfunction

   function automatic job_type noise_job();
      job_type jb;
      jb.func = func_type'($urandom_range(0, 3));
      jb.pid = 3'($urandom_range(0, 7));
      for (int j = 0; j < 3; j++) begin
         jb.amt[j] = 8'($urandom_range(0, 255));
         jb.held[j] = 8'($urandom_range(0, 255));
      end
      return jb;
   endfunction

   function automatic job_type load_job(int p);
      job_type jb;
      int room;
      jb.func = FN_LOAD;
      jb.pid = 3'(p);
      for (int j = 0; j < 3; j++) begin
         room = sat8(avail_vec[j] + alloc_tab[p][j]);
         jb.amt[j] = 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 12));
         jb.held[j] = 8'($urandom_range(0, (jb.amt[j] < room) ? jb.amt[j] : room));
      end
      return jb;
   endfunction

   function automatic job_type request_job(int p);
      job_type jb;
      int top;
      jb = noise_job();
      jb.func = FN_REQUEST;
      jb.pid = 3'(p);
      for (int j = 0; j < 3; j++) begin
         top = (need_tab[p][j] < avail_vec[j]) ? need_tab[p][j] : avail_vec[j];
         if (j < res_in_use()) jb.amt[j] = 8'($urandom_range(0, top));
      end
      return jb;
   endfunction

   // response side: ready follows a stall pattern drawn at random from four modes
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 48 == 0) stall_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= $urandom_range(0, 1);
            2:       rsp_if.ready <= ($urandom_range(0, 4) == 0);
            default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
            if (rsp_if.seq_proc !== want.seq_proc)
               report_mismatch("seq_proc", rsp_if.seq_proc, want.seq_proc);
            if (rsp_if.last !== want.last) report_mismatch("last", rsp_if.last, want.last);
            if (rsp_if.avail0 !== want.avail[0])
               report_mismatch("avail0", rsp_if.avail0, want.avail[0]);
            if (rsp_if.avail1 !== want.avail[1])
               report_mismatch("avail1", rsp_if.avail1, want.avail[1]);
            if (rsp_if.avail2 !== want.avail[2])
               report_mismatch("avail2", rsp_if.avail2, want.avail[2]);
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      job_type jb;
      int np;
      int ops;
      int sent;
      int want_status;
      beat_type tail;

      req_if.valid = 1'b0;
      req_if.func = FN_CLEAR;
      req_if.proc_index = '0;
      req_if.amount0 = '0;
      req_if.amount1 = '0;
      req_if.amount2 = '0;
      req_if.held0 = '0;
      req_if.held1 = '0;
      req_if.held2 = '0;
      rsp_if.ready = 1'b0;
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 3; j++) begin
            alloc_tab[i][j] = '0;
            need_tab[i][j] = '0;
         end
      for (int j = 0; j < 3; j++) begin
         avail_vec[j] = '0;
         cfg_total[j] = '0;
      end
      cfg_np = 4'd8;
      cfg_nr = 2'd3;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan.push_back(op(FN_CLEAR,   0, 0, 0, 0, 0, 0, 0, ST_OK));
      plan.push_back(op(FN_CHECK,   0, 0, 0, 0, 0, 0, 0, -1));
      plan.push_back(cfg(CSR_TOTAL0, 10));
      plan.push_back(cfg(CSR_TOTAL1, 5));
      plan.push_back(cfg(CSR_TOTAL2, 7));
      plan.push_back(cfg(CSR_NUM_PROCS, 5));
      plan.push_back(cfg(CSR_NUM_RES, 3));
      plan.push_back(op(FN_CLEAR,   0, 0, 0, 0, 0, 0, 0, ST_OK));
      plan.push_back(op(FN_LOAD,    0, 7, 5, 3, 0, 1, 0, ST_OK));
      plan.push_back(op(FN_LOAD,    1, 3, 2, 2, 2, 0, 0, ST_OK));
      plan.push_back(op(FN_LOAD,    2, 9, 0, 2, 3, 0, 2, ST_OK));
      plan.push_back(op(FN_LOAD,    3, 2, 2, 2, 2, 1, 1, ST_OK));
      plan.push_back(op(FN_LOAD,    4, 4, 3, 3, 0, 0, 2, ST_OK));
      plan.push_back(op(FN_LOAD,    5, 1, 1, 1, 0, 0, 0, ST_BAD_PROC));
      plan.push_back(op(FN_LOAD,    4, 1, 1, 1, 2, 0, 0, ST_BAD_LOAD));
      plan.push_back(op(FN_LOAD,    4, 255, 255, 255, 255, 0, 0, ST_BAD_LOAD));
      plan.push_back(op(FN_REQUEST, 1, 1, 0, 2, 0, 0, 0, -1));
      plan.push_back(op(FN_REQUEST, 0, 8, 0, 0, 0, 0, 0, ST_OVER_NEED));
      plan.push_back(op(FN_REQUEST, 4, 0, 0, 1, 0, 0, 0, ST_OVER_AVAIL));
      plan.push_back(op(FN_REQUEST, 6, 0, 0, 0, 0, 0, 0, ST_BAD_PROC));
      plan.push_back(op(FN_REQUEST, 0, 0, 2, 0, 0, 0, 0, -1));
      plan.push_back(op(FN_CHECK,   0, 0, 0, 0, 0, 0, 0, -1));
      plan.push_back(cfg(CSR_TOTAL0, 255));
      plan.push_back(cfg(CSR_TOTAL1, 255));
      plan.push_back(cfg(CSR_TOTAL2, 255));
      plan.push_back(cfg(CSR_NUM_PROCS, 8));
      plan.push_back(cfg(CSR_NUM_RES, 1));
      plan.push_back(op(FN_CLEAR,   0, 0, 0, 0, 0, 0, 0, ST_OK));
      plan.push_back(op(FN_LOAD,    7, 255, 255, 255, 255, 255, 255, ST_OK));
      plan.push_back(op(FN_LOAD,    0, 0, 0, 0, 1, 0, 0, ST_BAD_LOAD));
      plan.push_back(op(FN_REQUEST, 7, 0, 0, 0, 0, 0, 0, -1));
      plan.push_back(cfg(CSR_NUM_PROCS, 0));
      plan.push_back(cfg(CSR_NUM_RES, 0));
      plan.push_back(op(FN_CHECK,   0, 0, 0, 0, 0, 0, 0, -1));
      plan.push_back(op(FN_REQUEST, 1, 0, 0, 0, 0, 0, 0, ST_BAD_PROC));
      plan.push_back(op(FN_CLEAR,   0, 0, 0, 0, 0, 0, 0, ST_OK));

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            drain();
            write_csr(plan[k].idx, plan[k].wdata);
         end else begin
            send_job(plan[k].job, (k + 1 < plan.size()) && !plan[k + 1].is_csr);
            want_status = plan[k].want;
            if (want_status >= 0) begin
               tail = expected_beats[$];
               tail.status = status_type'(want_status);
               expected_beats[$] = tail;
            end
         end
      end

      sent = 0;
      while (sent < 140) begin
         drain();
         write_csr(CSR_TOTAL0, ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
         write_csr(CSR_TOTAL1, ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 40)));
         write_csr(CSR_TOTAL2, 8'($urandom_range(0, 255)));
         write_csr(CSR_NUM_PROCS, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(1, 8)));
         write_csr(CSR_NUM_RES, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(1, 3)));
         np = rows_in_use();
         jb = noise_job();
         jb.func = FN_CLEAR;
         send_job(jb, 1'b1);
         for (int p = 0; p < np; p++) send_job(load_job(p), 1'b1);
         sent += np + 1;
         ops = $urandom_range(6, 14);
         for (int k = 0; k < ops; k++) begin
            case ($urandom_range(0, 9))
               0:       begin jb = noise_job(); jb.func = FN_CHECK; end
               1:       jb = noise_job();
               2:       jb = load_job($urandom_range(0, np - 1));
               default: jb = request_job($urandom_range(0, np - 1));
            endcase
            send_job(jb, k + 1 < ops);
         end
         sent += ops;
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d beats still expected", expected_beats.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
